// File: hdl/aad_pkg.sv
// Shared types and constants for the area-averaging downscaler.
// Used by every module of the block; depends on nothing.
package aad_pkg;

    // Configuration register widths and indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int SRC_W_W    = 13;
    localparam int SRC_H_W    = 13;
    localparam int DST_W_W    = 12;
    localparam int DST_H_W    = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;

    localparam logic [SRC_W_W-1:0] RST_SOURCE_WIDTH  = 13'd640;
    localparam logic [SRC_H_W-1:0] RST_SOURCE_HEIGHT = 13'd480;
    localparam logic [DST_W_W-1:0] RST_TARGET_WIDTH  = 12'd320;
    localparam logic [DST_H_W-1:0] RST_TARGET_HEIGHT = 13'd240;

    // Pixel channel width and quotient bits of the average.
    localparam int CH_W      = 8;
    localparam int DIV_STEPS = 8;

    // Flags that travel with each queued word.
    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } item_flags_t;

    localparam int FLAGS_W = 3;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_WEIGHT,
        B_READ,
        B_WRITE,
        B_FETCH,
        B_LOAD,
        B_DIV
    } back_state_t;

    // Output stage states: empty, or holding a word.
    typedef enum logic {
        O_EMPTY,
        O_FULL
    } out_state_t;

endpackage

// File: hdl/aad_front.sv
// Front end: accepts source pixels, tracks grid position and computes overlap widths.
// Depends on aad_pkg.
module aad_front #(
    parameter int DW = 13,
    parameter int TW = 12,
    parameter int GW = 27,
    parameter int EW = 76,
    parameter int MAX_TARGET_WIDTH = 2048
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       restart,
    input  logic                       take,
    input  logic [aad_pkg::CH_W-1:0]   blue,
    input  logic [aad_pkg::CH_W-1:0]   green,
    input  logic [aad_pkg::CH_W-1:0]   red,
    input  logic [DW-1:0]              src_w,
    input  logic [DW-1:0]              src_h,
    input  logic [TW-1:0]              dst_w,
    input  logic [DW-1:0]              dst_h,
    output logic [EW-1:0]              word
);
    import aad_pkg::*;

    logic [DW-1:0] pcol_reg, pcol_next, prow_reg, prow_next;
    logic [TW-1:0] ccol_reg, ccol_next;
    logic [DW-1:0] crow_reg, crow_next;
    logic [GW-1:0] xs_reg, xs_next, ys_reg, ys_next;
    logic [GW-1:0] cedge_reg, cedge_next, redge_reg, redge_next;
    logic          bank_reg, bank_next;

    logic [GW-1:0] xe, ye;
    logic          col_done, row_done;
    logic [TW-1:0] wx0, wx1;
    logic [DW-1:0] wy0, wy1;
    item_flags_t   flags;

    // Overlap of this source pixel with the current and next cell.
    always_comb
    begin
        xe       = xs_reg + GW'(dst_w);
        ye       = ys_reg + GW'(dst_h);
        col_done = (xe >= cedge_reg);
        row_done = (ye >= redge_reg);
        if (xe <= cedge_reg)
        begin
            wx0 = dst_w;
            wx1 = '0;
        end
        else
        begin
            wx0 = TW'(cedge_reg - xs_reg);
            wx1 = TW'(xe - cedge_reg);
        end
        if (ye <= redge_reg)
        begin
            wy0 = dst_h;
            wy1 = '0;
        end
        else
        begin
            wy0 = DW'(redge_reg - ys_reg);
            wy1 = DW'(ye - redge_reg);
        end
        flags.emit      = col_done && row_done
                          && ((TW + 1)'(ccol_reg) < (TW + 1)'(MAX_TARGET_WIDTH));
        flags.row_end   = ((TW + 1)'(ccol_reg) + 1'b1) >= (TW + 1)'(dst_w);
        flags.frame_end = flags.row_end
                          && (((DW + 1)'(crow_reg) + 1'b1) >= (DW + 1)'(dst_h));
    end

    assign word = {flags, blue, green, red, bank_reg, ccol_reg, wx0, wx1, wy0, wy1};

    // Position update per accepted pixel; restart returns to the frame start.
    always_comb
    begin
        pcol_next  = pcol_reg;
        prow_next  = prow_reg;
        ccol_next  = ccol_reg;
        crow_next  = crow_reg;
        xs_next    = xs_reg;
        ys_next    = ys_reg;
        cedge_next = cedge_reg;
        redge_next = redge_reg;
        bank_next  = bank_reg;
        if (restart)
        begin
            pcol_next  = '0;
            prow_next  = '0;
            ccol_next  = '0;
            crow_next  = '0;
            xs_next    = '0;
            ys_next    = '0;
            cedge_next = GW'(src_w);
            redge_next = GW'(src_h);
            bank_next  = 1'b0;
        end
        else if (take)
        begin
            if (col_done)
            begin
                ccol_next  = ccol_reg + 1'b1;
                cedge_next = cedge_reg + GW'(src_w);
            end
            pcol_next = pcol_reg + 1'b1;
            xs_next   = xe;
            if (((DW + 1)'(pcol_reg) + 1'b1) >= (DW + 1)'(src_w))
            begin
                pcol_next  = '0;
                ccol_next  = '0;
                cedge_next = GW'(src_w);
                xs_next    = '0;
                if (row_done)
                begin
                    crow_next  = crow_reg + 1'b1;
                    redge_next = redge_reg + GW'(src_h);
                    bank_next  = ~bank_reg;
                end
                prow_next = prow_reg + 1'b1;
                ys_next   = ye;
                if (((DW + 1)'(prow_reg) + 1'b1) >= (DW + 1)'(src_h))
                begin
                    prow_next  = '0;
                    crow_next  = '0;
                    redge_next = GW'(src_h);
                    ys_next    = '0;
                    bank_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcol_reg  <= '0;
            prow_reg  <= '0;
            ccol_reg  <= '0;
            crow_reg  <= '0;
            xs_reg    <= '0;
            ys_reg    <= '0;
            cedge_reg <= '0;
            redge_reg <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            pcol_reg  <= pcol_next;
            prow_reg  <= prow_next;
            ccol_reg  <= ccol_next;
            crow_reg  <= crow_next;
            xs_reg    <= xs_next;
            ys_reg    <= ys_next;
            cedge_reg <= cedge_next;
            redge_reg <= redge_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

// File: hdl/aad_fifo.sv
// Two-entry queue between the front end and the accumulator sequencer.
// Depends on aad_pkg only by convention; carries an opaque word.
module aad_fifo #(
    parameter int EW = 76
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          flush,
    input  logic          push,
    input  logic [EW-1:0] push_word,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output logic [EW-1:0] pop_word
);
    import aad_pkg::*;

    logic [EW-1:0] store_reg [2];
    logic          wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_word  = store_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
        if (flush)
        begin
            wr_ptr_next = 1'b0;
            rd_ptr_next = 1'b0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: hdl/aad_back.sv
// Back end: line accumulator memories, weighted updates, averaging divider, output word.
// Depends on aad_pkg.
module aad_back #(
    parameter int DW = 13,
    parameter int TW = 12,
    parameter int EW = 76,
    parameter int MAX_TARGET_WIDTH = 2048
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      restart,
    output logic                      clearing,
    input  logic                      q_not_empty,
    input  logic [EW-1:0]             q_word,
    output logic                      q_pop,
    input  logic [2*DW-1:0]           area,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [aad_pkg::CH_W-1:0]  out_blue,
    output logic [aad_pkg::CH_W-1:0]  out_green,
    output logic [aad_pkg::CH_W-1:0]  out_red,
    output logic                      row_end,
    output logic                      frame_end
);
    import aad_pkg::*;

    localparam int AW    = $clog2(MAX_TARGET_WIDTH);
    localparam int DEPTH = 2 ** (AW + 1);
    localparam int SUMW  = 2 * DW + CH_W;
    localparam int WTW   = TW + DW;
    localparam int PRW   = WTW + CH_W;

    // Accumulator memories, one per channel.
    logic [SUMW-1:0] mem_b [DEPTH];
    logic [SUMW-1:0] mem_g [DEPTH];
    logic [SUMW-1:0] mem_r [DEPTH];
    logic [SUMW-1:0] rd_b_reg, rd_g_reg, rd_r_reg;

    back_state_t     state_reg, state_next;
    logic [EW-1:0]   word_reg;
    logic [1:0]      upd_reg, upd_next;
    logic [AW:0]     clr_cnt_reg;
    logic [WTW-1:0]  weight_reg;
    logic [AW:0]     addr_reg;
    logic [PRW-1:0]  prod_b_reg, prod_g_reg, prod_r_reg;
    logic [SUMW-1:0] rem_b_reg, rem_g_reg, rem_r_reg, dv_reg;
    logic [CH_W-1:0] q_b_reg, q_g_reg, q_r_reg;
    logic [2:0]      div_cnt_reg;
    out_state_t      ostate_reg;
    logic [CH_W-1:0] ob_reg, og_reg, or_reg;
    logic            orow_reg, oframe_reg;

    // Fields of the word in service.
    item_flags_t     w_flags;
    logic [CH_W-1:0] w_b, w_g, w_r;
    logic            w_bank;
    logic [TW-1:0]   w_col, w_wx0, w_wx1;
    logic [DW-1:0]   w_wy0, w_wy1;

    assign {w_flags, w_b, w_g, w_r, w_bank, w_col, w_wx0, w_wx1, w_wy0, w_wy1} = word_reg;

    // Selection of one of the four updates.
    logic          sel_bank;
    logic [TW:0]   sel_col;
    logic [TW-1:0] sel_wx;
    logic [DW-1:0] sel_wy;
    logic          sel_skip;
    logic [AW:0]   sel_addr, emit_addr;
    logic          out_free, last_upd;

    always_comb
    begin
        sel_bank  = w_bank ^ upd_reg[1];
        sel_col   = (TW + 1)'(w_col) + (TW + 1)'(upd_reg[0]);
        sel_wx    = upd_reg[0] ? w_wx1 : w_wx0;
        sel_wy    = upd_reg[1] ? w_wy1 : w_wy0;
        sel_skip  = (sel_wx == '0) || (sel_wy == '0)
                    || (sel_col >= (TW + 1)'(MAX_TARGET_WIDTH));
        sel_addr  = {sel_bank, sel_col[AW-1:0]};
        emit_addr = {w_bank, w_col[AW-1:0]};
        last_upd  = (upd_reg == 2'd3);
        out_free  = (ostate_reg == O_EMPTY) || !out_stall;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        upd_next   = upd_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_cnt_reg == (AW + 1)'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_not_empty)
                begin
                    state_next = B_WEIGHT;
                    upd_next   = '0;
                end
            end
            B_WEIGHT:
            begin
                if (!sel_skip)
                begin
                    state_next = B_READ;
                end
                else if (last_upd)
                begin
                    state_next = w_flags.emit ? B_FETCH : B_IDLE;
                end
                else
                begin
                    upd_next = upd_reg + 1'b1;
                end
            end
            B_READ:
            begin
                state_next = B_WRITE;
            end
            B_WRITE:
            begin
                if (last_upd)
                begin
                    state_next = w_flags.emit ? B_FETCH : B_IDLE;
                end
                else
                begin
                    state_next = B_WEIGHT;
                    upd_next   = upd_reg + 1'b1;
                end
            end
            B_FETCH:
            begin
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (div_cnt_reg == 3'(DIV_STEPS - 1) && out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (restart)
        begin
            state_next = B_CLEAR;
        end
    end

    // Memory port control.
    logic            mem_we, mem_re;
    logic [AW:0]     mem_addr;
    logic [SUMW-1:0] wd_b, wd_g, wd_r;

    always_comb
    begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = addr_reg;
        wd_b     = '0;
        wd_g     = '0;
        wd_r     = '0;
        q_pop    = 1'b0;
        case (state_reg)
            B_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
            end
            B_IDLE:
            begin
                q_pop = q_not_empty && !restart;
            end
            B_READ:
            begin
                mem_re = 1'b1;
            end
            B_WRITE:
            begin
                mem_we = 1'b1;
                wd_b   = rd_b_reg + SUMW'(prod_b_reg);
                wd_g   = rd_g_reg + SUMW'(prod_g_reg);
                wd_r   = rd_r_reg + SUMW'(prod_r_reg);
            end
            B_FETCH:
            begin
                mem_re   = 1'b1;
                mem_addr = emit_addr;
            end
            B_LOAD:
            begin
                mem_we   = 1'b1;
                mem_addr = emit_addr;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign clearing = (state_reg == B_CLEAR);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_b[mem_addr] <= wd_b;
            mem_g[mem_addr] <= wd_g;
            mem_r[mem_addr] <= wd_r;
        end
        if (mem_re)
        begin
            rd_b_reg <= mem_b[mem_addr];
            rd_g_reg <= mem_g[mem_addr];
            rd_r_reg <= mem_r[mem_addr];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            upd_reg     <= '0;
            clr_cnt_reg <= '0;
            div_cnt_reg <= '0;
            ostate_reg  <= O_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
            upd_reg   <= upd_next;
            if (restart || state_reg != B_CLEAR)
            begin
                clr_cnt_reg <= '0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == B_LOAD)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == B_DIV && div_cnt_reg != 3'(DIV_STEPS - 1))
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (state_reg == B_DIV && div_cnt_reg == 3'(DIV_STEPS - 1) && out_free)
            begin
                ostate_reg <= O_FULL;
            end
            else if (!out_stall)
            begin
                ostate_reg <= O_EMPTY;
            end
        end
    end

    // Datapath registers: word capture, weight, products, divider, output word.
    logic [SUMW-1:0] nb, ng, nr;
    logic            hold_div;

    always_comb
    begin
        hold_div = (div_cnt_reg == 3'(DIV_STEPS - 1));
        nb = rem_b_reg;
        ng = rem_g_reg;
        nr = rem_r_reg;
        if (rem_b_reg >= dv_reg) nb = rem_b_reg - dv_reg;
        if (rem_g_reg >= dv_reg) ng = rem_g_reg - dv_reg;
        if (rem_r_reg >= dv_reg) nr = rem_r_reg - dv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            word_reg <= q_word;
        end
        if (state_reg == B_WEIGHT)
        begin
            weight_reg <= WTW'(sel_wx) * WTW'(sel_wy);
            addr_reg   <= sel_addr;
        end
        if (state_reg == B_READ)
        begin
            prod_b_reg <= PRW'(weight_reg) * PRW'(w_b);
            prod_g_reg <= PRW'(weight_reg) * PRW'(w_g);
            prod_r_reg <= PRW'(weight_reg) * PRW'(w_r);
        end
        if (state_reg == B_LOAD)
        begin
            rem_b_reg <= rd_b_reg;
            rem_g_reg <= rd_g_reg;
            rem_r_reg <= rd_r_reg;
            dv_reg    <= SUMW'(area) << (DIV_STEPS - 1);
        end
        else if (state_reg == B_DIV && !hold_div)
        begin
            rem_b_reg <= nb;
            rem_g_reg <= ng;
            rem_r_reg <= nr;
            dv_reg    <= dv_reg >> 1;
            q_b_reg   <= {q_b_reg[CH_W-2:0], rem_b_reg >= dv_reg};
            q_g_reg   <= {q_g_reg[CH_W-2:0], rem_g_reg >= dv_reg};
            q_r_reg   <= {q_r_reg[CH_W-2:0], rem_r_reg >= dv_reg};
        end
        if (state_reg == B_DIV && hold_div && out_free)
        begin
            ob_reg     <= {q_b_reg[CH_W-2:0], rem_b_reg >= dv_reg};
            og_reg     <= {q_g_reg[CH_W-2:0], rem_g_reg >= dv_reg};
            or_reg     <= {q_r_reg[CH_W-2:0], rem_r_reg >= dv_reg};
            orow_reg   <= w_flags.row_end;
            oframe_reg <= w_flags.frame_end;
        end
    end

    assign out_valid = (ostate_reg == O_FULL);
    assign out_blue  = ob_reg;
    assign out_green = og_reg;
    assign out_red   = or_reg;
    assign row_end   = orow_reg;
    assign frame_end = oframe_reg;

    // The partial sum read for an output is zeroed right after the read.
    a_load_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FETCH && !restart) |=> (state_reg == B_LOAD))
        else $error("output fetch not followed by clearing load");

    // A memory update writes back to the address that it read.
    a_write_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WRITE) |-> $stable(addr_reg))
        else $error("accumulator address changed between read and write");

    // No queued word is taken while the memories are being cleared.
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !q_pop)
        else $error("word taken during clearing pass");

    // An output word appears only at the end of a division.
    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == B_DIV))
        else $error("output word without division");

endmodule

// File: hdl/area_average_downscale_rgb_unit.sv
// Area-averaging BGR downscaler, top level: config registers, front end, queue, back end.
// Depends on aad_pkg, aad_front, aad_fifo and aad_back.
// Sequence: the back end pops a word in B_IDLE; per overlap update (1 to 4 nonzero per pixel)
// it runs B_WEIGHT, B_READ, B_WRITE, or B_WEIGHT alone if skipped; an output adds B_FETCH,
// B_LOAD and B_DIV, whose end waits on out_stall. Up to two pixels queue while it works. Reset
// and each write to config indexes 0 to 3 clear the accumulators, in_stall high.
module area_average_downscale_rgb_unit #(
    parameter int MAX_SOURCE_DIM   = 4096,
    parameter int MAX_TARGET_WIDTH = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [aad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aad_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [aad_pkg::CH_W-1:0]       in_blue,
    input  logic [aad_pkg::CH_W-1:0]       in_green,
    input  logic [aad_pkg::CH_W-1:0]       in_red,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [aad_pkg::CH_W-1:0]       out_blue,
    output logic [aad_pkg::CH_W-1:0]       out_green,
    output logic [aad_pkg::CH_W-1:0]       out_red,
    output logic                           row_end,
    output logic                           frame_end
);
    import aad_pkg::*;

    localparam int DW  = $clog2(MAX_SOURCE_DIM + 1);
    localparam int TW  = $clog2(MAX_TARGET_WIDTH + 1);
    localparam int CW0 = (DW > TW) ? DW : TW;
    localparam int CW  = (CW0 > CFG_DATA_W) ? CW0 : CFG_DATA_W;
    localparam int GW  = 2 * DW + 1;
    localparam int EW  = FLAGS_W + 3 * CH_W + 1 + 3 * TW + 2 * DW;

    // Configuration registers.
    logic [SRC_W_W-1:0] src_w_reg;
    logic [SRC_H_W-1:0] src_h_reg;
    logic [DST_W_W-1:0] dst_w_reg;
    logic [DST_H_W-1:0] dst_h_reg;
    logic               restart;

    always_comb
    begin
        case (cfg_index)
            CFG_SOURCE_WIDTH, CFG_SOURCE_HEIGHT, CFG_TARGET_WIDTH, CFG_TARGET_HEIGHT:
                restart = cfg_we;
            default:
                restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= RST_SOURCE_WIDTH;
            src_h_reg <= RST_SOURCE_HEIGHT;
            dst_w_reg <= RST_TARGET_WIDTH;
            dst_h_reg <= RST_TARGET_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  src_w_reg <= SRC_W_W'(cfg_data);
                CFG_SOURCE_HEIGHT: src_h_reg <= SRC_H_W'(cfg_data);
                CFG_TARGET_WIDTH:  dst_w_reg <= DST_W_W'(cfg_data);
                CFG_TARGET_HEIGHT: dst_h_reg <= DST_H_W'(cfg_data);
                default:           src_w_reg <= src_w_reg;
            endcase
        end
    end

    // Effective sizes: zero reads as one, sources saturate, no upscaling.
    logic [CW-1:0] sw_c, sh_c, dw_lim, dw_c, dh_c, sw_x, sh_x, dw_x, dh_x;

    always_comb
    begin
        sw_x   = CW'(src_w_reg);
        sh_x   = CW'(src_h_reg);
        dw_x   = CW'(dst_w_reg);
        dh_x   = CW'(dst_h_reg);
        sw_c   = (sw_x == '0) ? CW'(1) : ((sw_x > CW'(MAX_SOURCE_DIM)) ? CW'(MAX_SOURCE_DIM) : sw_x);
        sh_c   = (sh_x == '0) ? CW'(1) : ((sh_x > CW'(MAX_SOURCE_DIM)) ? CW'(MAX_SOURCE_DIM) : sh_x);
        dw_lim = (sw_c < CW'(MAX_TARGET_WIDTH)) ? sw_c : CW'(MAX_TARGET_WIDTH);
        dw_c   = (dw_x == '0) ? CW'(1) : ((dw_x > dw_lim) ? dw_lim : dw_x);
        dh_c   = (dh_x == '0) ? CW'(1) : ((dh_x > sh_c) ? sh_c : dh_x);
    end

    logic [DW-1:0]   sw_reg, sh_reg, dh_reg;
    logic [TW-1:0]   dw_reg;
    logic [2*DW-1:0] area_reg;

    always_ff @(posedge clk)
    begin
        sw_reg   <= DW'(sw_c);
        sh_reg   <= DW'(sh_c);
        dw_reg   <= TW'(dw_c);
        dh_reg   <= DW'(dh_c);
        area_reg <= (2 * DW)'(sw_reg) * (2 * DW)'(sh_reg);
    end

    // Front end, queue and back end.
    logic          clearing, q_full, q_not_empty, q_pop, take;
    logic [EW-1:0] f_word, q_word;

    assign in_stall = clearing || q_full || cfg_we;
    assign take     = in_valid && !in_stall;

    aad_front #(
        .DW(DW), .TW(TW), .GW(GW), .EW(EW), .MAX_TARGET_WIDTH(MAX_TARGET_WIDTH)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .restart(clearing), .take(take),
        .blue(in_blue), .green(in_green), .red(in_red),
        .src_w(sw_reg), .src_h(sh_reg), .dst_w(dw_reg), .dst_h(dh_reg),
        .word(f_word)
    );

    aad_fifo #(.EW(EW)) u_fifo (
        .clk(clk), .rst_n(rst_n), .flush(restart),
        .push(take), .push_word(f_word), .full(q_full),
        .pop(q_pop), .not_empty(q_not_empty), .pop_word(q_word)
    );

    aad_back #(
        .DW(DW), .TW(TW), .EW(EW), .MAX_TARGET_WIDTH(MAX_TARGET_WIDTH)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .restart(restart), .clearing(clearing),
        .q_not_empty(q_not_empty), .q_word(q_word), .q_pop(q_pop),
        .area(area_reg),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
        .row_end(row_end), .frame_end(frame_end)
    );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for area_average_downscale_rgb_unit.
// Depends on aad_pkg and the block; a scoreboard class predicts each downscaled word.
module testbench;
    import aad_pkg::*;

    // One predicted destination pixel.
    typedef struct {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            row_end;
        logic            frame_end;
    } dest_pixel_t;

    // Predicts destination pixels from accepted source pixels and checks results.
    class downscale_scoreboard;
        localparam int SRC_MAX = 4096;
        localparam int DST_MAX = 2048;

        int unsigned       src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
        longint unsigned   acc_blue[2*DST_MAX];
        longint unsigned   acc_green[2*DST_MAX];
        longint unsigned   acc_red[2*DST_MAX];
        int unsigned       pix_col, pix_row, blk_col, blk_row;
        int unsigned       col_edge, row_edge, bank;
        dest_pixel_t       expected_pixels[$];
        int                errors;

        function new();
            src_w_reg = 32'(RST_SOURCE_WIDTH);
            src_h_reg = 32'(RST_SOURCE_HEIGHT);
            dst_w_reg = 32'(RST_TARGET_WIDTH);
            dst_h_reg = 32'(RST_TARGET_HEIGHT);
            errors = 0;
            restart();
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function int unsigned eff_src_w();
            return clamp(src_w_reg, SRC_MAX);
        endfunction

        function int unsigned eff_src_h();
            return clamp(src_h_reg, SRC_MAX);
        endfunction

        function int unsigned eff_dst_w();
            int unsigned lim;
            lim = (eff_src_w() < DST_MAX) ? eff_src_w() : DST_MAX;
            return clamp(dst_w_reg, lim);
        endfunction

        function int unsigned eff_dst_h();
            return clamp(dst_h_reg, eff_src_h());
        endfunction

        // A write to one of the four size registers restarts the frame and clears the line sums.
        function void restart();
            for (int i = 0; i < 2*DST_MAX; i++)
            begin
                acc_blue[i] = 0;
                acc_green[i] = 0;
                acc_red[i] = 0;
            end
            pix_col = 0;
            pix_row = 0;
            blk_col = 0;
            blk_row = 0;
            col_edge = eff_src_w();
            row_edge = eff_src_h();
            bank = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SOURCE_WIDTH:  src_w_reg = 32'(val);
                CFG_SOURCE_HEIGHT: src_h_reg = 32'(val);
                CFG_TARGET_WIDTH:  dst_w_reg = 32'(val[DST_W_W-1:0]);
                CFG_TARGET_HEIGHT: dst_h_reg = 32'(val);
                default:           return;
            endcase
            restart();
        endfunction

        function void add_weighted(int unsigned bk, int unsigned col, longint unsigned wt,
                                   longint unsigned b, longint unsigned g, longint unsigned r);
            int unsigned idx;
            if (wt == 0 || col >= DST_MAX) return;
            idx = (bk & 1) * DST_MAX + col;
            acc_blue[idx] += wt * b;
            acc_green[idx] += wt * g;
            acc_red[idx] += wt * r;
        endfunction

        // Spreads one source pixel over the cells it overlaps.
        function void note_pixel(logic [CH_W-1:0] b, logic [CH_W-1:0] g, logic [CH_W-1:0] r);
            int unsigned     sw, sh, dw, dh, xs, xe, ys, ye, idx;
            longint unsigned wx0, wx1, wy0, wy1, area;
            bit              col_done, row_done, last_col;
            dest_pixel_t     px;
            sw = eff_src_w();
            sh = eff_src_h();
            dw = eff_dst_w();
            dh = eff_dst_h();
            xs = pix_col * dw;
            xe = xs + dw;
            ys = pix_row * dh;
            ye = ys + dh;
            col_done = (xe >= col_edge);
            row_done = (ye >= row_edge);
            if (xe <= col_edge)
            begin
                wx0 = dw;
                wx1 = 0;
            end
            else
            begin
                wx0 = col_edge - xs;
                wx1 = xe - col_edge;
            end
            if (ye <= row_edge)
            begin
                wy0 = dh;
                wy1 = 0;
            end
            else
            begin
                wy0 = row_edge - ys;
                wy1 = ye - row_edge;
            end
            add_weighted(bank, blk_col, wx0 * wy0, b, g, r);
            add_weighted(bank, blk_col + 1, wx1 * wy0, b, g, r);
            add_weighted(bank ^ 1, blk_col, wx0 * wy1, b, g, r);
            add_weighted(bank ^ 1, blk_col + 1, wx1 * wy1, b, g, r);

            // A completed destination pixel is averaged and its entry cleared.
            if (col_done && row_done && blk_col < DST_MAX)
            begin
                idx = (bank & 1) * DST_MAX + blk_col;
                area = longint'(sw) * sh;
                last_col = (blk_col + 1 >= dw);
                px.blue = CH_W'(acc_blue[idx] / area);
                px.green = CH_W'(acc_green[idx] / area);
                px.red = CH_W'(acc_red[idx] / area);
                px.row_end = last_col;
                px.frame_end = last_col && (blk_row + 1 >= dh);
                acc_blue[idx] = 0;
                acc_green[idx] = 0;
                acc_red[idx] = 0;
                expected_pixels.push_back(px);
            end

            // Advance the source and destination positions.
            if (col_done)
            begin
                blk_col++;
                col_edge += sw;
            end
            pix_col++;
            if (pix_col >= sw)
            begin
                pix_col = 0;
                blk_col = 0;
                col_edge = sw;
                if (row_done)
                begin
                    blk_row++;
                    row_edge += sh;
                    bank ^= 1;
                end
                pix_row++;
                if (pix_row >= sh)
                begin
                    pix_row = 0;
                    blk_row = 0;
                    row_edge = sh;
                    bank = 0;
                end
            end
        endfunction

        function void check_word(dest_pixel_t got);
            dest_pixel_t exp_px;
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected output word: blue %0d green %0d red %0d",
                       got.blue, got.green, got.red);
                errors++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (got.blue !== exp_px.blue)
            begin
                $error("out_blue expected %0d actual %0d", exp_px.blue, got.blue);
                errors++;
            end
            if (got.green !== exp_px.green)
            begin
                $error("out_green expected %0d actual %0d", exp_px.green, got.green);
                errors++;
            end
            if (got.red !== exp_px.red)
            begin
                $error("out_red expected %0d actual %0d", exp_px.red, got.red);
                errors++;
            end
            if (got.row_end !== exp_px.row_end)
            begin
                $error("row_end expected %0d actual %0d", exp_px.row_end, got.row_end);
                errors++;
            end
            if (got.frame_end !== exp_px.frame_end)
            begin
                $error("frame_end expected %0d actual %0d", exp_px.frame_end, got.frame_end);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [CH_W-1:0]       in_blue;
    logic [CH_W-1:0]       in_green;
    logic [CH_W-1:0]       in_red;
    logic                  out_valid;
    logic                  out_stall;
    logic [CH_W-1:0]       out_blue;
    logic [CH_W-1:0]       out_green;
    logic [CH_W-1:0]       out_red;
    logic                  row_end;
    logic                  frame_end;

    downscale_scoreboard sb;
    int                  idle_cycles = 0;
    int                  stall_hold;
    bit                  send_burst;
    bit                  recv_burst;

    area_average_downscale_rgb_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_blue   (in_blue),
        .in_green  (in_green),
        .in_red    (in_red),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Random gap length: mostly short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver stall pattern, held for a random number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else if (recv_burst)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_hold <= pick_gap();
        end
    end

    // Output monitor: check every accepted word.
    always @(posedge clk)
    begin
        dest_pixel_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.blue = out_blue;
            got.green = out_green;
            got.red = out_red;
            got.row_end = row_end;
            got.frame_end = frame_end;
            sb.check_word(got);
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 30000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sends one source pixel and waits for it to be taken.
    task automatic send_pixel(logic [CH_W-1:0] b, logic [CH_W-1:0] g, logic [CH_W-1:0] r);
        int gap;
        in_valid <= 1'b1;
        in_blue <= b;
        in_green <= g;
        in_red <= r;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pixel(b, g, r);
        gap = send_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [CH_W-1:0] rand_channel();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return CH_W'($urandom_range(0, 255));
    endfunction

    // Waits until every predicted word has come and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
    endtask

    task automatic set_sizes(int sw, int sh, int dw, int dh);
        drain();
        write_reg(CFG_SOURCE_WIDTH, CFG_DATA_W'(sw));
        write_reg(CFG_SOURCE_HEIGHT, CFG_DATA_W'(sh));
        write_reg(CFG_TARGET_WIDTH, CFG_DATA_W'(dw));
        write_reg(CFG_TARGET_HEIGHT, CFG_DATA_W'(dh));
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 97 == 0)
            begin
                send_burst = ($urandom_range(0, 2) == 0);
                recv_burst = ($urandom_range(0, 2) == 0);
            end
            send_pixel(rand_channel(), rand_channel(), rand_channel());
        end
    endtask

    // Stimulus: directed extremes first, then random frames at several sizes.
    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_blue = '0;
        in_green = '0;
        in_red = '0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Default sizes with channel extremes.
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '1);
        send_pixel('1, '0, '1);
        send_pixel('0, '1, '0);
        for (int i = 0; i < 4; i++)
            send_pixel(8'h55 << (i % 2), 8'hAA >> (i % 2), 8'h0F << i);

        // Equal sizes pass pixels through.
        set_sizes(4, 4, 4, 4);
        send_pixel('1, '0, '1);
        send_pixel('0, '1, '0);
        send_pixel('1, '1, '1);
        send_pixel('0, '0, '0);
        random_phase(60);

        // Zero sizes act as one; an index past the list is ignored.
        set_sizes(0, 0, 0, 0);
        drain();
        write_reg(CFG_IDX_W'(5), 13'd3);
        write_reg(CFG_IDX_W'(7), '1);
        send_pixel('1, '1, '1);
        send_pixel('0, '0, '0);
        random_phase(30);

        // Oversized source saturates; widest destination row.
        set_sizes(8191, 1, 8191, 0);
        random_phase(200);

        // Uneven ratios with partial overlaps; one pause until all words arrive.
        set_sizes(7, 5, 3, 2);
        random_phase(150);
        drain();
        random_phase(150);

        set_sizes(13, 9, 5, 4);
        random_phase(300);

        // Upscaling requested saturates to the source size.
        set_sizes(6, 3, 4095, 8191);
        random_phase(200);

        set_sizes(5, 7, 2, 3);
        random_phase(300);

        drain();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: sim.f
hdl/aad_pkg.sv
hdl/aad_front.sv
hdl/aad_fifo.sv
hdl/aad_back.sv
hdl/area_average_downscale_rgb_unit.sv
tb/testbench.sv
